// ===== rtl/fss_pkg.sv =====
`timescale 1ns / 1ps

package fss_pkg;

   // Frame store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_AW     = $clog2(MAX_WIDTH);
   localparam int ROW_AW     = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_AW + ROW_AW;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   // Field and register widths
   localparam int SIZE_W     = 9;
   localparam int SIZE_LIMIT = 256;
   localparam int PIX_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Fixed point scaling
   localparam int FRAC_BITS  = 16;
   localparam int STEP_W     = 25;
   localparam int REM_W      = SIZE_W;
   localparam int DIV_STEPS  = STEP_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int PROD_W     = SIZE_W + STEP_W;
   localparam int COORD_W    = PROD_W - FRAC_BITS;
   localparam int OUT_SZ_W   = SIZE_W + 1;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_CURSOR = 2'd1,
      ACT_EMIT   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MODE_NEAREST  = 2'd0,
      MODE_POINT    = 2'd1,
      MODE_SCANLINE = 2'd2
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DSP_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DSP_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_MODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_KEY  = 3'd5;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd240;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_READ,
      ST_OUT
   } state_type;

   // Map a size of zero to one and clip anything above the limit
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_W'(SIZE_LIMIT)) begin
         r = SIZE_W'(SIZE_LIMIT);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/frame_store_scaler_scanout_core.sv =====
`timescale 1ns / 1ps

// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+------------------------------
// request   | req_action req_cursor_x req_cursor_y req_color | taken when start && !busy
// response  | rsp_pixel rsp_end_of_line rsp_end_of_frame    | rsp_valid, one cycle, no stall
// csr       | csr_index csr_wr_data                         | written when csr_wr_en
//
// Write-pixel and set-cursor items are taken while idle; busy stays low.
// An emit item passes through ST_MUL, ST_READ and ST_OUT; its result shows in ST_OUT.
// The first emit of an output frame passes through ST_DIV before ST_MUL: two 1-bit-per-cycle restoring
// dividers there recompute the 9.16 steps.
// Reset is synchronous; the frame memory is not cleared and needs no pass.
// The receiver cannot stall: each result is presented for exactly one cycle.

module frame_store_scaler_scanout_core
   import fss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic [COL_AW-1:0]     req_cursor_x,
   input  logic [ROW_AW-1:0]     req_cursor_y,
   input  logic [PIX_W-1:0]      req_color,
   // response channel
   output logic                  rsp_valid,
   output logic [PIX_W-1:0]      rsp_pixel,
   output logic                  rsp_end_of_line,
   output logic                  rsp_end_of_frame,
   // configuration port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [SIZE_W-1:0] src_width_ff, src_height_ff, dsp_width_ff, dsp_height_ff;
   logic [1:0]        scale_mode_ff;
   logic [PIX_W-1:0]  color_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIZE_RESET;
         src_height_ff <= SIZE_RESET;
         dsp_width_ff  <= SIZE_RESET;
         dsp_height_ff <= SIZE_RESET;
         scale_mode_ff <= MODE_NEAREST;
         color_key_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SRC_WIDTH:  src_width_ff  <= csr_wr_data[SIZE_W-1:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_wr_data[SIZE_W-1:0];
            REG_DSP_WIDTH:  dsp_width_ff  <= csr_wr_data[SIZE_W-1:0];
            REG_DSP_HEIGHT: dsp_height_ff <= csr_wr_data[SIZE_W-1:0];
            REG_SCALE_MODE: scale_mode_ff <= csr_wr_data[1:0];
            REG_COLOR_KEY:  color_key_ff  <= csr_wr_data[PIX_W-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // Effective sizes, already clipped to the legal range
   logic [SIZE_W-1:0] sw, sh, dw, dh;
   assign sw = clamp_size(src_width_ff);
   assign sh = clamp_size(src_height_ff);
   assign dw = clamp_size(dsp_width_ff);
   assign dh = clamp_size(dsp_height_ff);

   // ---------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------
   state_type state_ff, state_in;

   logic [COL_AW-1:0]    write_col_ff, write_col_in;
   logic [SIZE_W-1:0]    write_row_ff, write_row_in;
   logic [SIZE_W-1:0]    out_col_ff, out_col_in;
   logic [SIZE_W-1:0]    out_row_ff, out_row_in;
   logic [STEP_W-1:0]    step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [STEP_W-1:0]    quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [REM_W-1:0]     rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [PROD_W-1:0]    prod_x_ff, prod_y_ff;
   logic                 zero_ff, zero_in;
   logic                 eol_ff, eol_in, eof_ff, eof_in;
   logic [PIX_W-1:0]     rd_data_ff;

   logic accept, take_write, take_cursor, take_emit, at_origin, div_last;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign take_write  = accept && (req_action == ACT_WRITE);
   assign take_cursor = accept && (req_action == ACT_CURSOR);
   assign take_emit   = accept && (req_action == ACT_EMIT);
   assign at_origin   = (out_col_ff == '0) && (out_row_ff == '0);
   assign div_last    = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_emit) begin
               state_in = at_origin ? ST_DIV : ST_MUL;
            end
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_READ;
         ST_READ: state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Write cursor: store the color unless keyed out or off frame,
   // then advance and wrap to the next row at the source width
   // ---------------------------------------------------------------
   logic [COL_AW-1:0] wr_col_inc;
   logic              wr_wrap, wr_store;

   assign wr_col_inc = write_col_ff + COL_AW'(1);
   assign wr_wrap    = ({1'b0, wr_col_inc} >= sw) || (wr_col_inc == '0);
   assign wr_store   = take_write && (req_color != color_key_ff)
                       && ({1'b0, write_col_ff} < sw) && (write_row_ff < sh);

   always_comb begin
      write_col_in = write_col_ff;
      write_row_in = write_row_ff;
      priority if (take_write) begin
         if (wr_wrap) begin
            write_col_in = '0;
            // hold the row at its ceiling
            if (write_row_ff != '1) begin
               write_row_in = write_row_ff + SIZE_W'(1);
            end
         end else begin
            write_col_in = wr_col_inc;
         end
      end else if (take_cursor) begin
         write_col_in = req_cursor_x;
         write_row_in = {1'b0, req_cursor_y};
      end else begin
      end
   end

   // ---------------------------------------------------------------
   // Step dividers: (size << 16) / display_size + 1, one bit a cycle
   // ---------------------------------------------------------------
   logic [REM_W:0]    rsh_x, rsh_y, rsub_x, rsub_y;
   logic              ge_x, ge_y;
   logic [STEP_W-1:0] quo_x_nx, quo_y_nx;

   assign rsh_x    = {rem_x_ff, quo_x_ff[STEP_W-1]};
   assign rsh_y    = {rem_y_ff, quo_y_ff[STEP_W-1]};
   assign ge_x     = rsh_x >= {1'b0, dw};
   assign ge_y     = rsh_y >= {1'b0, dh};
   assign rsub_x   = rsh_x - {1'b0, dw};
   assign rsub_y   = rsh_y - {1'b0, dh};
   assign quo_x_nx = {quo_x_ff[STEP_W-2:0], ge_x};
   assign quo_y_nx = {quo_y_ff[STEP_W-2:0], ge_y};

   always_comb begin
      div_cnt_in = div_cnt_ff;
      quo_x_in   = quo_x_ff;
      quo_y_in   = quo_y_ff;
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      step_x_in  = step_x_ff;
      step_y_in  = step_y_ff;
      if (take_emit && at_origin) begin
         div_cnt_in = '0;
         quo_x_in   = {sw, FRAC_BITS'(0)};
         quo_y_in   = {sh, FRAC_BITS'(0)};
         rem_x_in   = '0;
         rem_y_in   = '0;
      end else if (state_ff == ST_DIV) begin
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         quo_x_in   = quo_x_nx;
         quo_y_in   = quo_y_nx;
         rem_x_in   = ge_x ? rsub_x[REM_W-1:0] : rsh_x[REM_W-1:0];
         rem_y_in   = ge_y ? rsub_y[REM_W-1:0] : rsh_y[REM_W-1:0];
         if (div_last) begin
            step_x_in = quo_x_nx + STEP_W'(1);
            step_y_in = quo_y_nx + STEP_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------
   // Source coordinate, output geometry and raster advance
   // ---------------------------------------------------------------
   logic                same;
   logic [COORD_W-1:0]  src_x, src_y;
   logic                blank, in_range;
   logic [OUT_SZ_W-1:0] out_w, out_h, col_inc, row_inc;
   logic [SIZE_W-2:0]   half_w;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;

   assign same   = (sw == dw) && (sh == dh);
   assign half_w = (SIZE_W-1)'(({1'b0, sw} + OUT_SZ_W'(1)) >> 1);

   always_comb begin
      blank = 1'b0;
      priority if (same) begin
         src_x = COORD_W'(out_col_ff);
         src_y = COORD_W'(out_row_ff);
         out_w = OUT_SZ_W'(sw);
         out_h = OUT_SZ_W'(sh);
      end else if (scale_mode_ff == MODE_NEAREST) begin
         src_x = prod_x_ff[PROD_W-1:FRAC_BITS];
         src_y = prod_y_ff[PROD_W-1:FRAC_BITS];
         out_w = OUT_SZ_W'(dw);
         out_h = OUT_SZ_W'(dh);
      end else begin
         src_x = COORD_W'(out_col_ff[SIZE_W-1:1]);
         src_y = COORD_W'(out_row_ff[SIZE_W-1:1]);
         out_w = {half_w, 2'b00};
         out_h = {sh, 1'b0};
         // scanline mode and the unused code blank odd columns
         blank = (scale_mode_ff != MODE_POINT) && out_col_ff[0];
      end
   end

   assign in_range = (src_x < COORD_W'(sw)) && (src_y < COORD_W'(sh));
   assign rd_addr  = {src_y[ROW_AW-1:0], src_x[COL_AW-1:0]};
   assign wr_addr  = {write_row_ff[ROW_AW-1:0], write_col_ff};
   assign col_inc  = {1'b0, out_col_ff} + OUT_SZ_W'(1);
   assign row_inc  = {1'b0, out_row_ff} + OUT_SZ_W'(1);

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      eol_in     = eol_ff;
      eof_in     = eof_ff;
      zero_in    = zero_ff;
      if (state_ff == ST_READ) begin
         zero_in = blank || !in_range;
         eol_in  = col_inc >= out_w;
         eof_in  = (col_inc >= out_w) && (row_inc >= out_h);
         if (col_inc >= out_w) begin
            out_col_in = '0;
            out_row_in = (row_inc >= out_h) ? '0 : row_inc[SIZE_W-1:0];
         end else begin
            out_col_in = col_inc[SIZE_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         write_col_ff <= '0;
         write_row_ff <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         div_cnt_ff   <= '0;
      end else begin
         write_col_ff <= write_col_in;
         write_row_ff <= write_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // Datapath registers, no reset needed
   always_ff @(posedge clock) begin
      quo_x_ff  <= quo_x_in;
      quo_y_ff  <= quo_y_in;
      rem_x_ff  <= rem_x_in;
      rem_y_ff  <= rem_y_in;
      zero_ff   <= zero_in;
      eol_ff    <= eol_in;
      eof_ff    <= eof_in;
      // one 9x25 product per axis, registered before use
      prod_x_ff <= {STEP_W'(0), out_col_ff} * {SIZE_W'(0), step_x_ff};
      prod_y_ff <= {STEP_W'(0), out_row_ff} * {SIZE_W'(0), step_y_ff};
   end

   // ---------------------------------------------------------------
   // Frame memory: one write port, one registered read port.
   // Writes finish in the accepting cycle, before any later read.
   // ---------------------------------------------------------------
   logic [PIX_W-1:0] frame_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_store) begin
         frame_mem[wr_addr] <= req_color;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------
   // Response
   // ---------------------------------------------------------------
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_pixel        = zero_ff ? '0 : rd_data_ff;
   assign rsp_end_of_line  = eol_ff;
   assign rsp_end_of_frame = eof_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_eof_on_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_line)
      else $error("end of frame without end of line");

   a_eol_wraps_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_line |-> (out_col_ff == '0))
      else $error("output column not wrapped after end of line");

   a_eof_wraps_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> (out_row_ff == '0))
      else $error("output row not wrapped after end of frame");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      take_emit |=> busy && !rsp_valid)
      else $error("emit item did not hold the block busy");

endmodule

// ===== tb/frame_store_scaler_scanout_core_test.sv =====
`timescale 1ns / 1ps

module frame_store_scaler_scanout_core_test
   import fss_pkg::*;
;

   // Action code that the block accepts and ignores
   localparam logic [1:0] ACT_IGNORED   = 2'd3;
   // Scale mode code outside the named modes; behaves as scanline doubling
   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam int PIXEL_REPEAT = 2;
   localparam int ITEM_TARGET  = 1950;
   // Longest emit also runs the step dividers; round up
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             end_of_line;
      logic             end_of_frame;
   } scan_pixel_type;

   // Shadow of the frame store and the scan-out position; predicts every emitted pixel
   class scanout_scoreboard;
      logic [PIX_W-1:0]  store [DEPTH];
      bit                written [DEPTH];
      logic [7:0]        wr_col;
      logic [8:0]        wr_row;
      logic [8:0]        out_col;
      logic [8:0]        out_row;
      logic [STEP_W-1:0] step_x;
      logic [STEP_W-1:0] step_y;
      logic [SIZE_W-1:0] cfg_src_width;
      logic [SIZE_W-1:0] cfg_src_height;
      logic [SIZE_W-1:0] cfg_dsp_width;
      logic [SIZE_W-1:0] cfg_dsp_height;
      logic [1:0]        cfg_scale_mode;
      logic [PIX_W-1:0]  cfg_color_key;
      scan_pixel_type    expected_pixels [$];
      int                mismatches;

      function new();
         wr_col         = '0;
         wr_row         = '0;
         out_col        = '0;
         out_row        = '0;
         step_x         = '0;
         step_y         = '0;
         cfg_src_width  = SIZE_RESET;
         cfg_src_height = SIZE_RESET;
         cfg_dsp_width  = SIZE_RESET;
         cfg_dsp_height = SIZE_RESET;
         cfg_scale_mode = MODE_NEAREST;
         cfg_color_key  = '0;
         mismatches     = 0;
      endfunction

      // Zero counts as one, anything past the limit is held at the limit
      function int unsigned eff(input logic [SIZE_W-1:0] v);
         if (v == '0) begin
            return 1;
         end
         return (v > SIZE_LIMIT) ? SIZE_LIMIT : v;
      endfunction

      function void sizes(output int unsigned sw, output int unsigned sh,
                          output int unsigned dw, output int unsigned dh);
         sw = eff(cfg_src_width);
         sh = eff(cfg_src_height);
         dw = eff(cfg_dsp_width);
         dh = eff(cfg_dsp_height);
      endfunction

      function void note_config(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_SRC_WIDTH:  cfg_src_width  = val[SIZE_W-1:0];
            REG_SRC_HEIGHT: cfg_src_height = val[SIZE_W-1:0];
            REG_DSP_WIDTH:  cfg_dsp_width  = val[SIZE_W-1:0];
            REG_DSP_HEIGHT: cfg_dsp_height = val[SIZE_W-1:0];
            REG_SCALE_MODE: cfg_scale_mode = val[1:0];
            REG_COLOR_KEY:  cfg_color_key  = val[PIX_W-1:0];
            default: ;
         endcase
      endfunction

      // Steps in use for the next emit: recomputed only at output origin
      function void frame_steps(output logic [STEP_W-1:0] kx,
                                output logic [STEP_W-1:0] ky);
         int unsigned sw, sh, dw, dh;
         longint unsigned num;
         sizes(sw, sh, dw, dh);
         kx = step_x;
         ky = step_y;
         if (out_col == '0 && out_row == '0) begin
            num = longint'(sw) << FRAC_BITS;
            kx  = STEP_W'(num / dw + 1);
            num = longint'(sh) << FRAC_BITS;
            ky  = STEP_W'(num / dh + 1);
         end
      endfunction

      // Source pixel the next emit reads; hit low means the pixel is black
      function void source_of(output bit hit, output int unsigned x, output int unsigned y);
         int unsigned sw, sh, dw, dh;
         logic [STEP_W-1:0] kx, ky;
         longint unsigned sx, sy;
         sizes(sw, sh, dw, dh);
         frame_steps(kx, ky);
         hit = 1'b1;
         sx  = out_col;
         sy  = out_row;
         if (sw == dw && sh == dh) begin
            // pass-through: output position is the source position
         end else if (cfg_scale_mode == MODE_NEAREST) begin
            sx = (sx * kx) >> FRAC_BITS;
            sy = (sy * ky) >> FRAC_BITS;
         end else begin
            // scanline modes blank every odd output column
            if (cfg_scale_mode != MODE_POINT && out_col[0]) begin
               hit = 1'b0;
            end
            sx = sx / PIXEL_REPEAT;
            sy = sy / PIXEL_REPEAT;
         end
         if (sx >= sw || sy >= sh) begin
            hit = 1'b0;
         end
         x = hit ? int'(sx) : 0;
         y = hit ? int'(sy) : 0;
      endfunction

      function void out_dims(output int unsigned ow, output int unsigned oh);
         int unsigned sw, sh, dw, dh;
         sizes(sw, sh, dw, dh);
         if (sw == dw && sh == dh) begin
            ow = sw;
            oh = sh;
         end else if (cfg_scale_mode == MODE_NEAREST) begin
            ow = dw;
            oh = dh;
         end else begin
            ow = 2 * PIXEL_REPEAT * ((sw + 1) / 2);
            oh = PIXEL_REPEAT * sh;
         end
      endfunction

      // Tell the stimulus which store entry must be written before the next emit
      function void needs_fill(output bit need, output logic [7:0] x, output logic [7:0] y);
         bit hit;
         int unsigned sx, sy;
         source_of(hit, sx, sy);
         x    = sx[7:0];
         y    = sy[7:0];
         need = hit && !written[{y, x}];
      endfunction

      function void note_item(input logic [1:0] act, input logic [7:0] x,
                              input logic [7:0] y, input logic [PIX_W-1:0] c);
         int unsigned sw, sh, dw, dh, sx, sy, ow, oh, ncol, nrow;
         bit hit;
         scan_pixel_type e;
         sizes(sw, sh, dw, dh);
         if (act == ACT_WRITE) begin
            if (c != cfg_color_key && wr_col < sw && wr_row < sh) begin
               store[{wr_row[7:0], wr_col}]   = c;
               written[{wr_row[7:0], wr_col}] = 1'b1;
            end
            wr_col = wr_col + 8'd1;
            if (wr_col >= sw || wr_col == '0) begin
               wr_col = '0;
               if (wr_row < 9'd511) begin
                  wr_row = wr_row + 9'd1;
               end
            end
         end else if (act == ACT_CURSOR) begin
            wr_col = x;
            wr_row = {1'b0, y};
         end else if (act == ACT_EMIT) begin
            frame_steps(step_x, step_y);
            source_of(hit, sx, sy);
            e.pixel        = hit ? store[{sy[7:0], sx[7:0]}] : '0;
            e.end_of_line  = 1'b0;
            e.end_of_frame = 1'b0;
            out_dims(ow, oh);
            ncol = out_col + 1;
            if (ncol >= ow) begin
               ncol          = 0;
               e.end_of_line = 1'b1;
               nrow          = out_row + 1;
               if (nrow >= oh) begin
                  nrow           = 0;
                  e.end_of_frame = 1'b1;
               end
               out_row = nrow[8:0];
            end
            out_col = ncol[8:0];
            expected_pixels.push_back(e);
         end
      endfunction

      function void check_result(input logic [PIX_W-1:0] pixel, input logic eol,
                                 input logic eof);
         scan_pixel_type e;
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel %h eol %b eof %b", pixel, eol, eof);
            mismatches++;
            return;
         end
         e = expected_pixels.pop_front();
         if (pixel !== e.pixel) begin
            $error("pixel: expected %h, got %h", e.pixel, pixel);
            mismatches++;
         end
         if (eol !== e.end_of_line) begin
            $error("end_of_line: expected %b, got %b", e.end_of_line, eol);
            mismatches++;
         end
         if (eof !== e.end_of_frame) begin
            $error("end_of_frame: expected %b, got %b", e.end_of_frame, eof);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_action;
   logic [COL_AW-1:0]     req_cursor_x;
   logic [ROW_AW-1:0]     req_cursor_y;
   logic [PIX_W-1:0]      req_color;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_pixel;
   logic                  rsp_end_of_line;
   logic                  rsp_end_of_frame;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   scanout_scoreboard sb = new();
   int  items_sent  = 0;
   int  cycle_count = 0;
   bit  burst       = 1'b0;

   frame_store_scaler_scanout_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_cursor_x     (req_cursor_x),
      .req_cursor_y     (req_cursor_y),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_pixel        (rsp_pixel),
      .rsp_end_of_line  (rsp_end_of_line),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results cannot be held off: take every strobed pixel at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_pixel, rsp_end_of_line, rsp_end_of_frame);
      end
   end

   // Watchdog: a hung handshake or a lost pixel ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one item at a falling edge after a random gap and hold it until taken.
   // Start stays high on return so a back-to-back item needs no gap.
   task automatic send_item(input logic [1:0] act, input logic [7:0] x, input logic [7:0] y,
                            input logic [PIX_W-1:0] c);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        = 1'b1;
      req_action   = act;
      req_cursor_x = x;
      req_cursor_y = y;
      req_color    = c;
      do @(posedge clock); while (busy);
      sb.note_item(act, x, y, c);
      if (act != ACT_IGNORED) begin
         items_sent++;
      end
   endtask

   // Drop start, wait out every expected pixel, then let trailing writes finish
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = val;
      sb.note_config(idx, val);
   endtask

   task automatic close_csr();
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_all(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                          input logic [SIZE_W-1:0] dw, input logic [SIZE_W-1:0] dh,
                          input logic [1:0] mode, input logic [PIX_W-1:0] key);
      set_register(REG_SRC_WIDTH, CSR_DATA_W'(sw));
      set_register(REG_SRC_HEIGHT, CSR_DATA_W'(sh));
      set_register(REG_DSP_WIDTH, CSR_DATA_W'(dw));
      set_register(REG_DSP_HEIGHT, CSR_DATA_W'(dh));
      set_register(REG_SCALE_MODE, CSR_DATA_W'(mode));
      set_register(REG_COLOR_KEY, key);
      close_csr();
   endtask

   // Colors hit the transparent key now and then
   function automatic logic [PIX_W-1:0] random_color();
      if ($urandom_range(0, 4) == 0) begin
         return sb.cfg_color_key;
      end
      return PIX_W'($urandom);
   endfunction

   // Mostly tiny sizes, a few near the limit, a few out of range
   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return SIZE_W'($urandom_range(1, 6));
      end else if (r < 75) begin
         return SIZE_W'($urandom_range(7, 40));
      end else if (r < 85) begin
         return ($urandom_range(0, 1) == 0) ? SIZE_W'(SIZE_LIMIT) : SIZE_W'($urandom_range(200, 256));
      end else if (r < 92) begin
         return '0;
      end
      return SIZE_W'($urandom_range(257, 511));
   endfunction

   // Emit one pixel; first write the source entry it reads if it was never stored
   task automatic emit_pixel();
      bit need;
      logic [7:0] fx, fy;
      logic [PIX_W-1:0] c;
      sb.needs_fill(need, fx, fy);
      if (need) begin
         send_item(ACT_CURSOR, fx, fy, PIX_W'($urandom));
         c = PIX_W'($urandom);
         if (c == sb.cfg_color_key) begin
            c = c ^ 16'h0001;
         end
         send_item(ACT_WRITE, 8'($urandom), 8'($urandom), c);
      end
      send_item(ACT_EMIT, 8'($urandom), 8'($urandom), PIX_W'($urandom));
   endtask

   // Write a small frame in raster order from the origin
   task automatic fill_frame();
      int unsigned count;
      count = sb.eff(sb.cfg_src_width) * sb.eff(sb.cfg_src_height);
      if (count <= 64) begin
         send_item(ACT_CURSOR, 8'd0, 8'd0, PIX_W'($urandom));
         repeat (count) send_item(ACT_WRITE, 8'($urandom), 8'($urandom), random_color());
      end
   endtask

   task automatic random_phase(input bit first);
      int n;
      int r;
      drain();
      if (first || $urandom_range(0, 9) < 6) begin
         set_register(REG_SRC_WIDTH, CSR_DATA_W'(pick_size()));
      end
      if (first || $urandom_range(0, 9) < 6) begin
         set_register(REG_SRC_HEIGHT, CSR_DATA_W'(pick_size()));
      end
      // favor equal sizes now and then so pass-through shows up
      if (first || $urandom_range(0, 9) < 6) begin
         set_register(REG_DSP_WIDTH, CSR_DATA_W'(($urandom_range(0, 9) < 3) ?
                      sb.cfg_src_width : pick_size()));
      end
      if (first || $urandom_range(0, 9) < 6) begin
         set_register(REG_DSP_HEIGHT, CSR_DATA_W'(($urandom_range(0, 9) < 3) ?
                      sb.cfg_src_height : pick_size()));
      end
      if (first || $urandom_range(0, 9) < 6) begin
         r = $urandom_range(0, 99);
         set_register(REG_SCALE_MODE, CSR_DATA_W'((r < 10) ? MODE_RESERVED :
                      (r < 40) ? MODE_NEAREST : (r < 70) ? MODE_POINT : MODE_SCANLINE));
      end
      if (first || $urandom_range(0, 9) < 6) begin
         set_register(REG_COLOR_KEY, $urandom_range(0, 1) ? PIX_W'($urandom) :
                      PIX_W'($urandom_range(0, 3)));
      end
      close_csr();
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
         fill_frame();
      end
      n = $urandom_range(15, 50);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            emit_pixel();
         end else if (r < 75) begin
            send_item(ACT_WRITE, 8'($urandom), 8'($urandom), random_color());
         end else if (r < 85) begin
            send_item(ACT_CURSOR, 8'($urandom), 8'($urandom), PIX_W'($urandom));
         end else if (r < 90) begin
            send_item(ACT_IGNORED, 8'($urandom), 8'($urandom), PIX_W'($urandom));
         end else if (r < 92) begin
            // hold off until the block has delivered everything
            drain();
         end else begin
            repeat (4) emit_pixel();
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_action   = ACT_WRITE;
      req_cursor_x = '0;
      req_cursor_y = '0;
      req_color    = '0;
      csr_wr_en    = 1'b0;
      csr_index    = REG_SRC_WIDTH;
      csr_wr_data  = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Reset settings: equal sizes, so pass-through, key of zero
      emit_pixel();
      emit_pixel();
      send_item(ACT_CURSOR, 8'd0, 8'd0, 16'h0000);
      send_item(ACT_WRITE, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(ACT_WRITE, 8'h00, 8'h00, 16'h0000);   // equals key: skipped
      send_item(ACT_WRITE, 8'h00, 8'h00, 16'h0001);
      send_item(ACT_IGNORED, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(ACT_CURSOR, 8'hFF, 8'hFF, 16'hFFFF);  // outside the frame: next write dropped
      send_item(ACT_WRITE, 8'h00, 8'h00, 16'h1234);
      send_item(ACT_CURSOR, 8'd239, 8'd239, 16'h0000); // last pixel, then row wrap
      send_item(ACT_WRITE, 8'h00, 8'h00, 16'h5678);
      send_item(ACT_WRITE, 8'h00, 8'h00, 16'h9ABC);
      emit_pixel();
      emit_pixel();
      emit_pixel();

      // Largest source squeezed to one pixel; column counter wraps at 255
      drain();
      set_all(9'd256, 9'd256, 9'd1, 9'd1, MODE_NEAREST, 16'hFFFF);
      emit_pixel();
      emit_pixel();
      emit_pixel();
      send_item(ACT_CURSOR, 8'd255, 8'd7, 16'h0000);
      send_item(ACT_WRITE, 8'h00, 8'h00, 16'hFFFF);
      send_item(ACT_WRITE, 8'h00, 8'h00, 16'h0000);

      // Zero sizes read as one, oversized display clipped; point doubling of odd width
      drain();
      set_all(9'd0, 9'd0, 9'd511, 9'd257, MODE_POINT, 16'h0000);
      repeat (5) emit_pixel();

      // Scanline doubling with a 3 by 2 frame
      drain();
      set_all(9'd3, 9'd2, 9'd5, 9'd1, MODE_SCANLINE, 16'hFFFF);
      fill_frame();
      repeat (8) emit_pixel();

      // Reserved mode; one-column frame drives the write row into saturation
      drain();
      set_all(9'd1, 9'd2, 9'd256, 9'd1, MODE_RESERVED, 16'h8000);
      burst = 1'b1;
      send_item(ACT_CURSOR, 8'd0, 8'd250, 16'h0000);
      repeat (265) send_item(ACT_WRITE, 8'($urandom), 8'($urandom), PIX_W'($urandom));
      burst = 1'b0;
      repeat (4) emit_pixel();

      random_phase(1'b1);
      while (items_sent < ITEM_TARGET) random_phase(1'b0);

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== frame_store_scaler_scanout_core.f =====
rtl/fss_pkg.sv
rtl/frame_store_scaler_scanout_core.sv
tb/frame_store_scaler_scanout_core_test.sv
